/* hdl/lprt_pkg.sv */
// Shared types and constants for the longest prefix route table.
package lprt_pkg;

  // Number of route slots, one cell each.
  localparam int unsigned Entries = 16;

  typedef enum logic [1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_ADD    = 2'd1,
    ACT_DELETE = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_e;

  // Request token that walks the chain, one cell per cycle.
  // hit means: lookup found a route, add placed the entry, delete found the prefix.
  typedef struct packed {
    action_e     action;
    logic [31:0] address;
    logic [31:0] prefix_mask;
    logic [31:0] gateway;
    logic        is_direct;
    logic        hit;
    logic [31:0] best_mask;
    logic [31:0] best_hop;
    logic        best_direct;
  } tok_t;

  // Contents of one route slot.
  typedef struct packed {
    logic        valid;
    logic [31:0] prefix;
    logic [31:0] mask;
    logic [31:0] next_hop;
    logic        direct;
  } slot_t;

  // One result item.
  typedef struct packed {
    status_e     status;
    logic [31:0] hop_address;
    logic        route_direct;
    logic [31:0] match_mask;
  } res_t;

endpackage

/* hdl/lprt_cell.sv */
// One route slot. Applies the passing token to its slot and hands the token on.
module lprt_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           tok_valid_i,
  input  lprt_pkg::tok_t tok_i,
  input  lprt_pkg::slot_t nbr_i,
  output logic           tok_valid_o,
  output lprt_pkg::tok_t tok_o,
  output lprt_pkg::slot_t slot_o
);

  logic            valid_q, valid_d;
  logic [31:0]     prefix_q, prefix_d;
  logic [31:0]     mask_q, mask_d;
  logic [31:0]     hop_q, hop_d;
  logic            direct_q, direct_d;
  logic            tok_valid_q;
  lprt_pkg::tok_t  tok_q, tok_d;
  logic            match;

  assign match = valid_q && ((tok_i.address & mask_q) == (prefix_q & mask_q));

  // Apply the token to this slot
  always_comb begin
    tok_d    = tok_i;
    valid_d  = valid_q;
    prefix_d = prefix_q;
    mask_d   = mask_q;
    hop_d    = hop_q;
    direct_d = direct_q;
    if (tok_valid_i) begin
      unique case (tok_i.action)
        lprt_pkg::ACT_LOOKUP: begin
          // later slot wins on equal masks
          if (match && (!tok_i.hit || (mask_q >= tok_i.best_mask))) begin
            tok_d.hit         = 1'b1;
            tok_d.best_mask   = mask_q;
            tok_d.best_hop    = direct_q ? tok_i.address : hop_q;
            tok_d.best_direct = direct_q;
          end
        end
        lprt_pkg::ACT_ADD: begin
          // first free slot takes the new route
          if (!valid_q && !tok_i.hit) begin
            tok_d.hit = 1'b1;
            valid_d   = 1'b1;
            prefix_d  = tok_i.address;
            mask_d    = tok_i.prefix_mask;
            hop_d     = tok_i.gateway;
            direct_d  = tok_i.is_direct;
          end
        end
        lprt_pkg::ACT_DELETE: begin
          // from the matching slot onward, pull the next slot down
          if (tok_i.hit || (valid_q && (prefix_q == tok_i.address))) begin
            tok_d.hit = 1'b1;
            valid_d   = nbr_i.valid;
            prefix_d  = nbr_i.prefix;
            mask_d    = nbr_i.mask;
            hop_d     = nbr_i.next_hop;
            direct_d  = nbr_i.direct;
          end
        end
        default: ;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      tok_valid_q <= 1'b0;
    end else begin
      valid_q     <= valid_d;
      tok_valid_q <= tok_valid_i;
    end
  end

  // Slot payload and token payload
  always_ff @(posedge clk_i) begin
    prefix_q <= prefix_d;
    mask_q   <= mask_d;
    hop_q    <= hop_d;
    direct_q <= direct_d;
    tok_q    <= tok_d;
  end

  assign tok_valid_o     = tok_valid_q;
  assign tok_o           = tok_q;
  assign slot_o.valid    = valid_q;
  assign slot_o.prefix   = prefix_q;
  assign slot_o.mask     = mask_q;
  assign slot_o.next_hop = hop_q;
  assign slot_o.direct   = direct_q;

endmodule

/* hdl/lprt_out.sv */
// Turns the finished token into a result and holds it in an output register
// with one skid entry behind it.
module lprt_out (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           tok_valid_i,
  input  lprt_pkg::tok_t tok_i,
  input  logic           out_stall_i,
  output logic           out_valid_o,
  output lprt_pkg::res_t res_o,
  output logic           skid_full_o
);

  lprt_pkg::res_t res_d;
  lprt_pkg::res_t out_q, skid_q;
  logic           out_valid_q, out_valid_d;
  logic           skid_valid_q, skid_valid_d;
  logic           out_free;
  logic           load_out, out_from_skid, load_skid;

  // Build the result from the final token
  always_comb begin
    res_d.status       = lprt_pkg::ST_MISS;
    res_d.hop_address  = '0;
    res_d.route_direct = 1'b0;
    res_d.match_mask   = '0;
    unique case (tok_i.action)
      lprt_pkg::ACT_LOOKUP: begin
        if (tok_i.hit) begin
          res_d.status       = lprt_pkg::ST_OK;
          res_d.hop_address  = tok_i.best_hop;
          res_d.route_direct = tok_i.best_direct;
          res_d.match_mask   = tok_i.best_mask;
        end
      end
      lprt_pkg::ACT_ADD:    res_d.status = tok_i.hit ? lprt_pkg::ST_OK : lprt_pkg::ST_FULL;
      lprt_pkg::ACT_DELETE: res_d.status = tok_i.hit ? lprt_pkg::ST_OK : lprt_pkg::ST_MISS;
      default: ;
    endcase
  end

  assign out_free = !out_valid_q || !out_stall_i;

  // Steer the result into the output register or the skid entry
  always_comb begin
    out_valid_d   = out_valid_q;
    skid_valid_d  = skid_valid_q;
    load_out      = 1'b0;
    out_from_skid = 1'b0;
    load_skid     = 1'b0;
    priority if (out_free && skid_valid_q) begin
      out_valid_d   = 1'b1;
      load_out      = 1'b1;
      out_from_skid = 1'b1;
      skid_valid_d  = tok_valid_i;
      load_skid     = tok_valid_i;
    end else if (out_free) begin
      out_valid_d = tok_valid_i;
      load_out    = tok_valid_i;
    end else begin
      // hold the output; park a finished result in the skid entry
      skid_valid_d = skid_valid_q || tok_valid_i;
      load_skid    = tok_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= out_from_skid ? skid_q : res_d;
    end
    if (load_skid) begin
      skid_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;
  assign skid_full_o = skid_valid_q;

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without an output result");
  a_skid_no_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> !tok_valid_i)
    else $error("token finished while skid entry full");
`endif

endmodule

/* hdl/longest_prefix_route_table.sv */
// Channel | valid       | stall        | payload
// --------+-------------+--------------+-------------------------------------------------
// in      | in_valid_i  | in_stall_o   | action_i address_i prefix_mask_i gateway_i is_direct_i
// out     | out_valid_o | out_stall_i  | status_o hop_address_o route_direct_o match_mask_o
//
// One request at a time walks the row of Entries slot cells, one cell per cycle.
// A result passes the input token register, the slot cells and the output register in that
// order; the next input is taken only once the token has left the chain.
// Reset (rst_ni low) empties the table and drops any request in flight.
// A stalled result sits in the output register; one more finished result fits in
// a skid entry, and the input stalls while that entry is occupied.
module longest_prefix_route_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [31:0] address_i,
  input  logic [31:0] prefix_mask_i,
  input  logic [31:0] gateway_i,
  input  logic        is_direct_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] hop_address_o,
  output logic        route_direct_o,
  output logic [31:0] match_mask_o
);

  localparam int unsigned N = lprt_pkg::Entries;

  logic [N:0]      tv;
  lprt_pkg::tok_t  tok [N+1];
  lprt_pkg::slot_t slot [N+1];
  lprt_pkg::tok_t  tok0_d;
  lprt_pkg::res_t  res;
  logic            in_xfer;
  logic            busy_q, busy_d;
  logic            tv0_q;
  lprt_pkg::tok_t  tok0_q;
  logic            skid_full;

  assign in_stall_o = busy_q || skid_full;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // Fresh token for the accepted request
  always_comb begin
    tok0_d.action      = lprt_pkg::action_e'(action_i);
    tok0_d.address     = address_i;
    tok0_d.prefix_mask = prefix_mask_i;
    tok0_d.gateway     = gateway_i;
    tok0_d.is_direct   = is_direct_i;
    tok0_d.hit         = 1'b0;
    tok0_d.best_mask   = '0;
    tok0_d.best_hop    = '0;
    tok0_d.best_direct = 1'b0;
  end

  // Busy from the transfer until the token leaves the chain
  always_comb begin
    priority if (in_xfer) begin
      busy_d = 1'b1;
    end else if (tv[N]) begin
      busy_d = 1'b0;
    end else begin
      busy_d = busy_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      tv0_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      tv0_q  <= in_xfer;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      tok0_q <= tok0_d;
    end
  end

  assign tv[0]   = tv0_q;
  assign tok[0]  = tok0_q;
  assign slot[N] = '0;

  // Row of slot cells; each pulls from its right neighbor on a delete
  for (genvar i = 0; i < N; i++) begin : g_cell
    lprt_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .tok_valid_i (tv[i]),
      .tok_i       (tok[i]),
      .nbr_i       (slot[i+1]),
      .tok_valid_o (tv[i+1]),
      .tok_o       (tok[i+1]),
      .slot_o      (slot[i])
    );
  end

  lprt_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (tv[N]),
    .tok_i       (tok[N]),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .res_o       (res),
    .skid_full_o (skid_full)
  );

  assign status_o       = res.status;
  assign hop_address_o  = res.hop_address;
  assign route_direct_o = res.route_direct;
  assign match_mask_o   = res.match_mask;

`ifndef ASSERT_OFF
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tv))
    else $error("more than one token in the chain");
  a_busy_has_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (|tv))
    else $error("busy with no token in the chain");
  a_token_has_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (|tv) |-> busy_q)
    else $error("token in the chain while not busy");
  a_table_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !slot[0].valid |-> !slot[1].valid)
    else $error("table not packed from the first slot");
`endif

endmodule

/* dv/tb_top.sv */
module tb_top;

  // Action code that the block does not define; it must answer with a miss.
  localparam logic [1:0] ActUnused = 2'd3;

  localparam lprt_pkg::res_t NoRoute   = '{lprt_pkg::ST_MISS, 32'h0, 1'b0, 32'h0};
  localparam lprt_pkg::res_t DoneOk    = '{lprt_pkg::ST_OK, 32'h0, 1'b0, 32'h0};
  localparam lprt_pkg::res_t TableFull = '{lprt_pkg::ST_FULL, 32'h0, 1'b0, 32'h0};

  localparam int unsigned RandomItems = 500;
  localparam int unsigned LongHold    = 400;

  typedef struct {
    logic [1:0]     act;
    logic [31:0]    addr;
    logic [31:0]    mask;
    logic [31:0]    gw;
    logic           dir;
    bit             pinned;
    lprt_pkg::res_t want;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  action_i;
  logic [31:0] address_i;
  logic [31:0] prefix_mask_i;
  logic [31:0] gateway_i;
  logic        is_direct_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  status_o;
  logic [31:0] hop_address_o;
  logic        route_direct_o;
  logic [31:0] match_mask_o;

  longest_prefix_route_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .address_i     (address_i),
    .prefix_mask_i (prefix_mask_i),
    .gateway_i     (gateway_i),
    .is_direct_i   (is_direct_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .hop_address_o (hop_address_o),
    .route_direct_o(route_direct_o),
    .match_mask_o  (match_mask_o)
  );

  // Shadow copy of the route table, packed from slot 0 upward
  logic [31:0] rt_prefix [lprt_pkg::Entries];
  logic [31:0] rt_mask   [lprt_pkg::Entries];
  logic [31:0] rt_hop    [lprt_pkg::Entries];
  logic        rt_direct [lprt_pkg::Entries];
  int unsigned rt_count;

  lprt_pkg::res_t route_exp_q [$];
  int unsigned    fail_cnt;
  int unsigned    results_seen;
  int unsigned    n_hit, n_nohit, n_added, n_full, n_del_ok, n_del_miss, n_unused;

  // Apply one request to the shadow table and return the answer it gives
  function automatic lprt_pkg::res_t route_apply(logic [1:0] act, logic [31:0] addr,
                                                 logic [31:0] mask, logic [31:0] gw,
                                                 logic dir);
    lprt_pkg::res_t r;
    bit             found;
    int unsigned    pick;
    int unsigned    k;
    r     = NoRoute;
    found = 1'b0;
    pick  = 0;
    case (act)
      lprt_pkg::ACT_LOOKUP: begin
        for (k = 0; k < rt_count; k++) begin
          if ((addr & rt_mask[k]) == (rt_prefix[k] & rt_mask[k]) &&
              (!found || rt_mask[k] >= rt_mask[pick])) begin
            found = 1'b1;
            pick  = k;
          end
        end
        if (found) begin
          r.status       = lprt_pkg::ST_OK;
          r.route_direct = rt_direct[pick];
          r.hop_address  = rt_direct[pick] ? addr : rt_hop[pick];
          r.match_mask   = rt_mask[pick];
        end
      end
      lprt_pkg::ACT_ADD: begin
        if (rt_count >= lprt_pkg::Entries) begin
          r.status = lprt_pkg::ST_FULL;
        end else begin
          rt_prefix[rt_count] = addr;
          rt_mask[rt_count]   = mask;
          rt_hop[rt_count]    = gw;
          rt_direct[rt_count] = dir;
          rt_count++;
          r.status = lprt_pkg::ST_OK;
        end
      end
      lprt_pkg::ACT_DELETE: begin
        for (k = 0; k < rt_count; k++) begin
          if (!found && rt_prefix[k] == addr) begin
            found = 1'b1;
            pick  = k;
          end
        end
        if (found) begin
          // close the gap left by the removed route
          for (k = pick; k + 1 < rt_count; k++) begin
            rt_prefix[k] = rt_prefix[k + 1];
            rt_mask[k]   = rt_mask[k + 1];
            rt_hop[k]    = rt_hop[k + 1];
            rt_direct[k] = rt_direct[k + 1];
          end
          rt_count--;
          r.status = lprt_pkg::ST_OK;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] len_mask(int unsigned len);
    return (len == 0) ? 32'h0 : 32'hFFFF_FFFF << (32 - len);
  endfunction

  function automatic stim_row_t row(logic [1:0] act, logic [31:0] addr,
                                    logic [31:0] mask, logic [31:0] gw,
                                    logic dir, bit pinned, lprt_pkg::res_t want);
    stim_row_t r;
    r.act    = act;
    r.addr   = addr;
    r.mask   = mask;
    r.gw     = gw;
    r.dir    = dir;
    r.pinned = pinned;
    r.want   = want;
    return r;
  endfunction

  task automatic note_fail(string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("%0t: %s", $time, msg);
  endtask

  // Offer one request, hold it until the transfer, then record its answer
  task automatic send_route_req(stim_row_t s);
    lprt_pkg::res_t want;
    in_valid_i    <= 1'b1;
    action_i      <= s.act;
    address_i     <= s.addr;
    prefix_mask_i <= s.mask;
    gateway_i     <= s.gw;
    is_direct_i   <= s.dir;
    do @(posedge clk_i); while (in_stall_o);
    want = route_apply(s.act, s.addr, s.mask, s.gw, s.dir);
    if (s.pinned) want = s.want;
    route_exp_q = {route_exp_q, want};
    case (s.act)
      lprt_pkg::ACT_LOOKUP: if (want.status == lprt_pkg::ST_OK) n_hit++; else n_nohit++;
      lprt_pkg::ACT_ADD:    if (want.status == lprt_pkg::ST_OK) n_added++; else n_full++;
      lprt_pkg::ACT_DELETE:
        if (want.status == lprt_pkg::ST_OK) n_del_ok++; else n_del_miss++;
      default:              n_unused++;
    endcase
  endtask

  // Drop valid for the given gap and put junk on the payload meanwhile
  task automatic idle_gap(int unsigned n);
    if (n == 0) return;
    in_valid_i    <= 1'b0;
    action_i      <= 2'($urandom_range(0, 3));
    address_i     <= $urandom;
    prefix_mask_i <= $urandom;
    gateway_i     <= $urandom;
    is_direct_i   <= 1'($urandom_range(0, 1));
    repeat (n) @(posedge clk_i);
  endtask

  function automatic int unsigned pick_gap(bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (route_exp_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hold reset low at the start and give every input a known value
  initial begin
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    action_i      <= lprt_pkg::ACT_LOOKUP;
    address_i     <= 32'h0;
    prefix_mask_i <= 32'h0;
    gateway_i     <= 32'h0;
    is_direct_i   <= 1'b0;
    out_stall_i   <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #(20 * 500000);
    $display("tb_top: FAIL");
    $finish;
  end

  // Check each result transfer against the oldest expected answer
  always @(posedge clk_i) begin
    lprt_pkg::res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (route_exp_q.size() == 0) begin
        note_fail($sformatf("unexpected result: status %0d hop %h dir %0d mask %h",
                            status_o, hop_address_o, route_direct_o, match_mask_o));
      end else begin
        want = route_exp_q.pop_front();
        if (status_o !== want.status || hop_address_o !== want.hop_address ||
            route_direct_o !== want.route_direct || match_mask_o !== want.match_mask)
          note_fail($sformatf({"mismatch: status %0d/%0d hop %h/%h dir %0d/%0d ",
                               "mask %h/%h (expected/actual)"},
                              want.status, status_o, want.hop_address, hop_address_o,
                              want.route_direct, route_direct_o,
                              want.match_mask, match_mask_o));
      end
    end
  end

  // Receiver: random stalls, quiet stretches, and one long hold-off
  initial begin : result_sink
    int unsigned r;
    int unsigned len;
    bit          held;
    held = 1'b0;
    wait (rst_ni);
    forever begin
      r = $urandom_range(0, 99);
      if (!held && results_seen >= 150) begin
        held = 1'b1;
        out_stall_i <= 1'b1;
        len = LongHold;
      end else if (r < 50) begin
        out_stall_i <= 1'b0;
        len = $urandom_range(1, 8);
      end else if (r < 60) begin
        out_stall_i <= 1'b0;
        len = $urandom_range(50, 120);
      end else if (r < 92) begin
        out_stall_i <= 1'b1;
        len = $urandom_range(1, 3);
      end else begin
        out_stall_i <= 1'b1;
        len = $urandom_range(20, 60);
      end
      repeat (len) @(posedge clk_i);
    end
  end

  // Sender: directed table first, then constrained-random route traffic
  initial begin : route_stim
    stim_row_t   rows [$];
    stim_row_t   s;
    logic [31:0] pfx_pool [4];
    int unsigned i;
    int unsigned k;
    int unsigned r;
    int unsigned p_add;
    int unsigned p_del;
    bit          quiet;

    pfx_pool = '{32'h0A00_0000, 32'hC0A8_0100, 32'hAC10_0000, 32'h8000_0000};

    rows = {rows, row(lprt_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0, 1'b1,
                      NoRoute)};
    rows = {rows, row(ActUnused, 32'hA5A5_A5A5, 32'hFFFF_FFFF, 32'h5A5A_5A5A, 1'b1,
                      1'b1, NoRoute)};
    // default route, then a host route at the top of the address space
    rows = {rows, row(lprt_pkg::ACT_ADD, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b0, 1'b1,
                      DoneOk)};
    rows = {rows, row(lprt_pkg::ACT_LOOKUP, 32'h1234_5678, 32'h0, 32'h0, 1'b0, 1'b1,
                      '{lprt_pkg::ST_OK, 32'hFFFF_FFFF, 1'b0, 32'h0})};
    rows = {rows, row(lprt_pkg::ACT_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hDEAD_BEEF,
                      1'b1, 1'b1, DoneOk)};
    // direct route: the destination comes back, the stored gateway never does
    rows = {rows, row(lprt_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0, 1'b1,
                      '{lprt_pkg::ST_OK, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF})};
    rows = {rows, row(lprt_pkg::ACT_ADD, 32'h0A00_0000, 32'hFF00_0000, 32'h0A00_00FE,
                      1'b0, 1'b1, DoneOk)};
    rows = {rows, row(lprt_pkg::ACT_ADD, 32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_00FE,
                      1'b1, 1'b1, DoneOk)};
    rows = {rows, row(lprt_pkg::ACT_LOOKUP, 32'h0A01_0203, 32'h0, 32'h0, 1'b0, 1'b0,
                      '0)};
    // same prefix and mask again: the later route wins the tie
    rows = {rows, row(lprt_pkg::ACT_ADD, 32'h0A00_0000, 32'hFF00_0000, 32'h0B0B_0B0B,
                      1'b0, 1'b1, DoneOk)};
    rows = {rows, row(lprt_pkg::ACT_LOOKUP, 32'h0A7F_0001, 32'h0, 32'h0, 1'b0, 1'b0,
                      '0)};
    rows = {rows, row(lprt_pkg::ACT_DELETE, 32'h0102_0304, 32'h0, 32'h0, 1'b0, 1'b1,
                      NoRoute)};
    // fill every remaining slot, then overflow
    for (i = 0; i < 11; i++)
      rows = {rows, row(lprt_pkg::ACT_ADD, 32'hC0A8_0000 | (i << 8), 32'hFFFF_FF00, i,
                        1'(i), 1'b1, DoneOk)};
    rows = {rows, row(lprt_pkg::ACT_ADD, 32'h0102_0304, 32'hFFFF_FFFF, 32'h1, 1'b0,
                      1'b1, TableFull)};
    // remove the first of two equal prefixes, then the last slot
    rows = {rows, row(lprt_pkg::ACT_DELETE, 32'h0A00_0000, 32'h0, 32'h0, 1'b0, 1'b1,
                      DoneOk)};
    rows = {rows, row(lprt_pkg::ACT_LOOKUP, 32'h0A7F_0001, 32'h0, 32'h0, 1'b0, 1'b0,
                      '0)};
    rows = {rows, row(lprt_pkg::ACT_DELETE, 32'hC0A8_0A00, 32'h0, 32'h0, 1'b0, 1'b1,
                      DoneOk)};

    wait (rst_ni);
    @(posedge clk_i);
    foreach (rows[j]) begin
      send_route_req(rows[j]);
      idle_gap(pick_gap(1'b0));
    end
    wait_drained();

    quiet = 1'b0;
    for (i = 0; i < RandomItems; i++) begin
      if (i % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
      // alternate phases that push toward a full table and toward an empty one
      if ((i / 64) % 2 == 1) begin
        p_add = 50;
        p_del = 60;
      end else begin
        p_add = 25;
        p_del = 60;
      end
      s.pinned = 1'b0;
      s.want   = '0;
      s.gw     = $urandom;
      s.dir    = 1'($urandom_range(0, 1));
      s.mask   = $urandom;
      s.addr   = $urandom;
      r = $urandom_range(0, 99);
      if (r < 3) begin
        s.act = ActUnused;
      end else if (r < p_add) begin
        s.act = lprt_pkg::ACT_ADD;
        r = $urandom_range(0, 99);
        if (r < 40) s.addr = pfx_pool[$urandom_range(0, 3)];
        else if (r < 70 && rt_count != 0) s.addr = rt_prefix[$urandom_range(0, rt_count - 1)];
        r = $urandom_range(0, 99);
        if (r < 45) s.mask = len_mask(8 * $urandom_range(0, 4));
        else if (r < 85) s.mask = len_mask($urandom_range(0, 32));
      end else if (r < p_del) begin
        s.act = lprt_pkg::ACT_DELETE;
        if (rt_count != 0 && $urandom_range(0, 99) < 75)
          s.addr = rt_prefix[$urandom_range(0, rt_count - 1)];
      end else begin
        s.act = lprt_pkg::ACT_LOOKUP;
        if (rt_count != 0 && $urandom_range(0, 99) < 70) begin
          k = $urandom_range(0, rt_count - 1);
          s.addr = (rt_prefix[k] & rt_mask[k]) | ($urandom & ~rt_mask[k]);
        end
      end
      send_route_req(s);
      if (i == RandomItems / 2) wait_drained();
      else idle_gap(pick_gap(quiet));
    end

    wait_drained();
    repeat (2 * lprt_pkg::Entries + 8) @(posedge clk_i);
    fail_cnt += route_exp_q.size();

    $display("tb_top: lookups %0d routed / %0d unrouted, adds %0d placed / %0d refused",
             n_hit, n_nohit, n_added, n_full);
    $display("tb_top: deletes %0d removed / %0d missed, %0d unused codes, %0d mismatches",
             n_del_ok, n_del_miss, n_unused, fail_cnt);
    if (fail_cnt == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/lprt_pkg.sv
hdl/lprt_cell.sv
hdl/lprt_out.sv
hdl/longest_prefix_route_table.sv
dv/tb_top.sv
